// ===== hw/rtl/fbfla_pkg.sv =====
// package for the fixed block free list allocator
// widths, codes, control structs and the size alignment function
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbfla_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int WORD_BYTES = 8;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int OFF_W      = 20;
	localparam int SIZE_W     = 13;
	localparam int ASIZE_W    = SIZE_W + 1;
	localparam int POOL_W     = OFF_W + 1;
	localparam int CFG_W      = POOL_W;
	localparam int WB_SH      = $clog2(WORD_BYTES);
	localparam int DIV_CNT_W  = $clog2(OFF_W);

	localparam logic [OFF_W-1:0]  HDR_OFF    = OFF_W'(WORD_BYTES);
	localparam logic [POOL_W-1:0] POOL_LIMIT = POOL_W'(1) << OFF_W;
	localparam logic [CNT_W-1:0]  CNT_MAX    = CNT_W'(MAX_BLOCKS);

	typedef enum logic [1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_REINIT = 2'd2
	} kind_t;

	typedef enum logic {
		REG_UNIT_REQ = 1'b0,
		REG_POOL_LEN = 1'b1
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_DIV,
		ST_WALK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [OFF_W-1:0] off;
		logic [IDX_W-1:0] idx;
	} link_t;

	typedef struct packed {
		logic load;
		logic ram_rd;
		logic div_start;
		logic walk_init;
		logic walk_step;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       head_empty;
		logic       off_low;
		logic       div_done;
		logic       n_zero;
		logic       walk_last;
		logic       out_free;
	} dp_status_t;

	function automatic logic [ASIZE_W-1:0] align_size(input logic [SIZE_W-1:0] req);
		logic [ASIZE_W-1:0] t;
		t = {1'b0, req} + ASIZE_W'(WORD_BYTES - 1);
		if (req < SIZE_W'(WORD_BYTES)) begin
			return ASIZE_W'(WORD_BYTES);
		end
		return {t[ASIZE_W-1:WB_SH], WB_SH'(0)};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fbfla_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on fbfla_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbfla_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [fbfla_pkg::OFF_W-1:0]   dividend,
	input  wire logic [fbfla_pkg::ASIZE_W-1:0] divisor,
	output logic                              done,
	output logic [fbfla_pkg::OFF_W-1:0]        quotient,
	output logic [fbfla_pkg::ASIZE_W-1:0]      remainder
);

	logic                                busy_q;
	logic [fbfla_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [fbfla_pkg::ASIZE_W-1:0]       div_q;
	logic [fbfla_pkg::ASIZE_W-1:0]       rem_q;
	logic [fbfla_pkg::OFF_W-1:0]         quo_q;
	logic [fbfla_pkg::ASIZE_W:0]         shifted;
	logic [fbfla_pkg::ASIZE_W:0]         diff;
	logic                                take;

	assign shifted = {rem_q, quo_q[fbfla_pkg::OFF_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign take    = shifted >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= fbfla_pkg::DIV_CNT_W'(fbfla_pkg::OFF_W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= take ? diff[fbfla_pkg::ASIZE_W-1:0] : shifted[fbfla_pkg::ASIZE_W-1:0];
			quo_q <= {quo_q[fbfla_pkg::OFF_W-2:0], take};
		end
	end

	assign done      = !busy_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fbfla_datapath.sv =====
// datapath: config and list registers, link memory, divider, result register
// depends on fbfla_pkg and fbfla_div
`timescale 1ns / 1ps
`default_nettype none

module fbfla_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [fbfla_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic [1:0]                  kind,
	input  wire logic [fbfla_pkg::OFF_W-1:0]  block_offset,
	input  wire fbfla_pkg::ctrl_cmd_t        cmd,
	output fbfla_pkg::dp_status_t            status,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [fbfla_pkg::OFF_W-1:0]       alloc_offset,
	output logic                             ok,
	output logic [fbfla_pkg::CNT_W-1:0]       free_count
);

	logic [fbfla_pkg::SIZE_W-1:0]  unit_req_q;
	logic [fbfla_pkg::POOL_W-1:0]  pool_len_q;
	logic [fbfla_pkg::ASIZE_W-1:0] aligned_q;
	logic [fbfla_pkg::OFF_W-1:0]   head_q;
	logic [fbfla_pkg::IDX_W-1:0]   head_idx_q;
	logic [fbfla_pkg::CNT_W-1:0]   count_q;
	logic [1:0]                    kind_q;
	logic [fbfla_pkg::OFF_W-1:0]   off_q;
	logic [fbfla_pkg::IDX_W-1:0]   walk_i_q;
	logic [fbfla_pkg::OFF_W-1:0]   walk_acc_q;
	logic                          out_valid_q;
	logic [fbfla_pkg::OFF_W-1:0]   res_off_q;
	logic                          res_ok_q;
	logic [fbfla_pkg::CNT_W-1:0]   res_cnt_q;

	fbfla_pkg::link_t              link_mem [fbfla_pkg::MAX_BLOCKS];
	fbfla_pkg::link_t              rdata_q;
	fbfla_pkg::link_t              wdata;
	logic [fbfla_pkg::IDX_W-1:0]   waddr;
	logic                          we;

	logic [fbfla_pkg::POOL_W-1:0]  pool_c;
	logic [fbfla_pkg::OFF_W-1:0]   dividend;
	logic                          div_done;
	logic [fbfla_pkg::OFF_W-1:0]   quo;
	logic [fbfla_pkg::ASIZE_W-1:0] rem;
	logic [fbfla_pkg::CNT_W-1:0]   n_blocks;
	logic                          walk_last;
	logic                          free_ok;
	logic                          out_free;

	logic [fbfla_pkg::OFF_W-1:0]   head_d;
	logic [fbfla_pkg::IDX_W-1:0]   head_idx_d;
	logic [fbfla_pkg::CNT_W-1:0]   count_d;
	logic [fbfla_pkg::OFF_W-1:0]   res_off_d;
	logic                          res_ok_d;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_req_q <= fbfla_pkg::SIZE_W'(fbfla_pkg::WORD_BYTES);
			pool_len_q <= '0;
		end else if (cfg_we) begin
			case (fbfla_pkg::reg_idx_t'(cfg_index))
				fbfla_pkg::REG_UNIT_REQ: unit_req_q <= cfg_data[fbfla_pkg::SIZE_W-1:0];
				fbfla_pkg::REG_POOL_LEN: pool_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider operands
	assign pool_c = (pool_len_q > fbfla_pkg::POOL_LIMIT) ? fbfla_pkg::POOL_LIMIT : pool_len_q;

	always_comb begin
		dividend = '0;
		if (kind_q == fbfla_pkg::KIND_FREE) begin
			dividend = off_q - fbfla_pkg::HDR_OFF;
		end else if (pool_c > {1'b0, fbfla_pkg::HDR_OFF}) begin
			dividend = fbfla_pkg::OFF_W'(pool_c - {1'b0, fbfla_pkg::HDR_OFF});
		end
	end

	fbfla_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (aligned_q),
		.done      (div_done),
		.quotient  (quo),
		.remainder (rem)
	);

	assign n_blocks = (quo >= fbfla_pkg::OFF_W'(fbfla_pkg::MAX_BLOCKS)) ?
		fbfla_pkg::CNT_MAX : quo[fbfla_pkg::CNT_W-1:0];
	assign walk_last = ({1'b0, walk_i_q} + 1'b1) == n_blocks;
	assign free_ok = (off_q >= fbfla_pkg::HDR_OFF) && (rem == '0) &&
		(quo[fbfla_pkg::OFF_W-1:fbfla_pkg::IDX_W] == '0);

	// item registers and reinitialize walk
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			off_q  <= block_offset;
		end
		if (cmd.walk_init) begin
			walk_i_q   <= '0;
			walk_acc_q <= fbfla_pkg::HDR_OFF + fbfla_pkg::OFF_W'(aligned_q);
		end else if (cmd.walk_step) begin
			walk_i_q   <= walk_i_q + 1'b1;
			walk_acc_q <= walk_acc_q + fbfla_pkg::OFF_W'(aligned_q);
		end
	end

	// link memory
	always_comb begin
		we    = 1'b0;
		waddr = walk_i_q;
		wdata = '0;
		if (cmd.walk_step) begin
			we = 1'b1;
			if (!walk_last) begin
				wdata.off = walk_acc_q;
				wdata.idx = walk_i_q + 1'b1;
			end
		end else if (cmd.commit && kind_q == fbfla_pkg::KIND_FREE && free_ok) begin
			we        = 1'b1;
			waddr     = quo[fbfla_pkg::IDX_W-1:0];
			wdata.off = head_q;
			wdata.idx = head_idx_q;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			link_mem[waddr] <= wdata;
		end
		if (cmd.ram_rd) begin
			rdata_q <= link_mem[head_idx_q];
		end
	end

	// commit of one item
	always_comb begin
		head_d     = head_q;
		head_idx_d = head_idx_q;
		count_d    = count_q;
		res_off_d  = '0;
		res_ok_d   = 1'b0;
		case (fbfla_pkg::kind_t'(kind_q))
			fbfla_pkg::KIND_ALLOC: begin
				if (head_q != '0) begin
					res_off_d  = head_q;
					res_ok_d   = 1'b1;
					head_d     = rdata_q.off;
					head_idx_d = rdata_q.idx;
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
				end
			end
			fbfla_pkg::KIND_FREE: begin
				if (free_ok) begin
					res_ok_d   = 1'b1;
					head_d     = off_q;
					head_idx_d = quo[fbfla_pkg::IDX_W-1:0];
					if (count_q < fbfla_pkg::CNT_MAX) begin
						count_d = count_q + 1'b1;
					end
				end
			end
			fbfla_pkg::KIND_REINIT: begin
				res_ok_d   = 1'b1;
				head_d     = (n_blocks != '0) ? fbfla_pkg::HDR_OFF : '0;
				head_idx_d = '0;
				count_d    = n_blocks;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aligned_q   <= fbfla_pkg::ASIZE_W'(fbfla_pkg::WORD_BYTES);
			head_q      <= '0;
			head_idx_q  <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load && kind == fbfla_pkg::KIND_REINIT) begin
				aligned_q <= fbfla_pkg::align_size(unit_req_q);
			end
			if (cmd.commit) begin
				head_q      <= head_d;
				head_idx_q  <= head_idx_d;
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_off_q <= res_off_d;
			res_ok_q  <= res_ok_d;
			res_cnt_q <= count_d;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	assign status.kind       = kind_q;
	assign status.head_empty = (head_q == '0);
	assign status.off_low    = (off_q < fbfla_pkg::HDR_OFF);
	assign status.div_done   = div_done;
	assign status.n_zero     = (n_blocks == '0);
	assign status.walk_last  = walk_last;
	assign status.out_free   = out_free;

	assign out_valid    = out_valid_q;
	assign alloc_offset = res_off_q;
	assign ok           = res_ok_q;
	assign free_count   = res_cnt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/fbfla_ctrl.sv =====
// controller state machine sequencing alloc, free and reinitialize
// depends on fbfla_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbfla_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire fbfla_pkg::dp_status_t status,
	output fbfla_pkg::ctrl_cmd_t       cmd
);

	fbfla_pkg::state_t state_q;
	fbfla_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfla_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			fbfla_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = fbfla_pkg::ST_DECODE;
				end
			end
			fbfla_pkg::ST_DECODE: begin
				case (fbfla_pkg::kind_t'(status.kind))
					fbfla_pkg::KIND_ALLOC: begin
						cmd.ram_rd = !status.head_empty;
						state_d    = fbfla_pkg::ST_FINISH;
					end
					fbfla_pkg::KIND_FREE: begin
						if (status.off_low) begin
							state_d = fbfla_pkg::ST_FINISH;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = fbfla_pkg::ST_DIV;
						end
					end
					fbfla_pkg::KIND_REINIT: begin
						cmd.div_start = 1'b1;
						state_d       = fbfla_pkg::ST_DIV;
					end
					default: state_d = fbfla_pkg::ST_FINISH;
				endcase
			end
			fbfla_pkg::ST_DIV: begin
				if (status.div_done) begin
					if (status.kind == fbfla_pkg::KIND_REINIT && !status.n_zero) begin
						cmd.walk_init = 1'b1;
						state_d       = fbfla_pkg::ST_WALK;
					end else begin
						state_d = fbfla_pkg::ST_FINISH;
					end
				end
			end
			fbfla_pkg::ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					state_d = fbfla_pkg::ST_FINISH;
				end
			end
			fbfla_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = fbfla_pkg::ST_IDLE;
				end
			end
			default: state_d = fbfla_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/fixed_block_free_list_allocator_unit.sv =====
// top level of the fixed block free list allocator
// depends on fbfla_pkg, fbfla_ctrl and fbfla_datapath
//
// Pool of equal blocks kept on a LIFO free list in a 1024-entry link memory.
// The block size and pool size registers take effect at the next reinitialize
// item. An item is taken only while the controller is idle; a finished result
// waits in the output register while the next item runs. An allocate reads the
// link memory, then updates the head at commit; a free below the header goes
// from decode straight to the finish state. A free runs the 20-step divider that
// turns the offset into a block number. Reinitialize runs the divider to find n
// linked blocks, then does one link memory write per block. Each commit waits for
// the output register to be free. No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_free_list_allocator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [fbfla_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  kind,
	input  wire logic [fbfla_pkg::OFF_W-1:0]  block_offset,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [fbfla_pkg::OFF_W-1:0]       alloc_offset,
	output logic                             ok,
	output logic [fbfla_pkg::CNT_W-1:0]       free_count
);

	fbfla_pkg::ctrl_cmd_t  cmd;
	fbfla_pkg::dp_status_t status;

	fbfla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	fbfla_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.kind         (kind),
		.block_offset (block_offset),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.alloc_offset (alloc_offset),
		.ok           (ok),
		.free_count   (free_count)
	);

endmodule

`default_nettype wire

// ===== dv/fixed_block_free_list_allocator_unit_tb.sv =====
// testbench for fixed_block_free_list_allocator_unit: directed and random alloc, free and
// reinitialize traffic with random stalls, results checked against a free list model
// depends on fbfla_pkg and the allocator rtl
`timescale 1ns / 1ps

module fixed_block_free_list_allocator_unit_tb;

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int unsigned POOL_CAP = 1 << fbfla_pkg::OFF_W;
	localparam int unsigned WB = fbfla_pkg::WORD_BYTES;
	localparam int unsigned MAXB = fbfla_pkg::MAX_BLOCKS;
	localparam int IDLE_PCT = 13;
	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 6000;
	localparam int RAND_PHASES = 7;
	localparam int PHASE_ITEMS = 64;

	typedef struct packed {
		logic [1:0]                  op;
		logic [fbfla_pkg::OFF_W-1:0] off;
	} alloc_req_t;

	typedef struct packed {
		logic [fbfla_pkg::OFF_W-1:0] offset;
		logic                        okay;
		logic [fbfla_pkg::CNT_W-1:0] count;
	} alloc_resp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [fbfla_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = '0;
	logic [fbfla_pkg::OFF_W-1:0] block_offset = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [fbfla_pkg::OFF_W-1:0] alloc_offset;
	logic ok;
	logic [fbfla_pkg::CNT_W-1:0] free_count;

	alloc_req_t pending_reqs[$];
	alloc_resp_t expected_resps[$];
	alloc_resp_t want_resp;
	int err_count = 0;
	int stall_cycles = 0;
	int hold_left = 0;
	logic hold_done = 1'b0;
	logic hold_request = 1'b0;
	logic no_idle = 1'b0;

	// free list model state and its copy of the registers
	int unsigned list_head = 0;
	int unsigned free_blocks = 0;
	int unsigned latched_unit = WB;
	int unsigned cfg_block = 8;
	int unsigned cfg_pool = 0;
	logic [fbfla_pkg::OFF_W-1:0] link_mem [fbfla_pkg::MAX_BLOCKS];

	// block geometry as the stimulus sees it
	int unsigned gen_unit = WB;
	int unsigned gen_blocks = 0;

	always #2 clk = ~clk;

	fixed_block_free_list_allocator_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.block_offset(block_offset),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.alloc_offset(alloc_offset),
		.ok(ok),
		.free_count(free_count)
	);

	function automatic int unsigned unit_bytes(input int unsigned req);
		if (req < WB) begin
			return WB;
		end
		return ((req + WB - 1) / WB) * WB;
	endfunction

	function automatic int unsigned block_total(input int unsigned req, input int unsigned pool);
		int unsigned lim;
		int unsigned n;
		lim = (pool > POOL_CAP) ? POOL_CAP : pool;
		n = (lim > WB) ? (lim - WB) / unit_bytes(req) : 0;
		return (n > MAXB) ? MAXB : n;
	endfunction

	task automatic predict_alloc_result(input alloc_req_t r);
		alloc_resp_t e;
		int unsigned idx;
		int unsigned n;
		int unsigned off;
		e = '0;
		off = 32'(r.off);
		case (r.op)
			fbfla_pkg::KIND_ALLOC: begin
				if (list_head != 0) begin
					idx = (list_head - WB) / latched_unit;
					e.offset = fbfla_pkg::OFF_W'(list_head);
					e.okay = 1'b1;
					list_head = (idx < MAXB) ? 32'(link_mem[idx]) : 32'd0;
					if (free_blocks > 0) begin
						free_blocks--;
					end
				end
			end
			fbfla_pkg::KIND_FREE: begin
				if (off >= WB && (off - WB) % latched_unit == 0) begin
					idx = (off - WB) / latched_unit;
					if (idx < MAXB) begin
						link_mem[idx] = fbfla_pkg::OFF_W'(list_head);
						list_head = off;
						if (free_blocks < MAXB) begin
							free_blocks++;
						end
						e.okay = 1'b1;
					end
				end
			end
			fbfla_pkg::KIND_REINIT: begin
				latched_unit = unit_bytes(cfg_block);
				n = block_total(cfg_block, cfg_pool);
				for (int unsigned i = 0; i < n; i++) begin
					link_mem[i] = (i + 1 < n) ?
						fbfla_pkg::OFF_W'(WB + (i + 1) * latched_unit) : '0;
				end
				list_head = (n != 0) ? WB : 0;
				free_blocks = n;
				e.okay = 1'b1;
			end
			default: begin
			end
		endcase
		e.count = fbfla_pkg::CNT_W'(free_blocks);
		expected_resps.push_back(e);
	endtask

	task automatic add_req(input logic [1:0] op, input logic [fbfla_pkg::OFF_W-1:0] off);
		alloc_req_t r;
		r.op = op;
		r.off = off;
		pending_reqs.push_back(r);
		if (op == fbfla_pkg::KIND_REINIT) begin
			gen_unit = unit_bytes(cfg_block);
			gen_blocks = block_total(cfg_block, cfg_pool);
		end
	endtask

	task automatic write_reg(input fbfla_pkg::reg_idx_t idx,
		input logic [fbfla_pkg::CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fbfla_pkg::REG_UNIT_REQ) begin
			cfg_block = 32'(val[fbfla_pkg::SIZE_W-1:0]);
		end else begin
			cfg_pool = 32'(val);
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || in_valid || expected_resps.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind <= '0;
			block_offset <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_alloc_result('{op: kind, off: block_offset});
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
					in_valid <= 1'b1;
					kind <= pending_reqs[0].op;
					block_offset <= pending_reqs[0].off;
					void'(pending_reqs.pop_front());
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_resps.size() == 0) begin
					$display("%0t: unexpected transfer: offset %0h ok %0b count %0d",
						$time, alloc_offset, ok, free_count);
					err_count++;
				end else begin
					want_resp = expected_resps.pop_front();
					if (alloc_offset !== want_resp.offset) begin
						$display("%0t: alloc_offset expected %0h actual %0h",
							$time, want_resp.offset, alloc_offset);
						err_count++;
					end
					if (ok !== want_resp.okay) begin
						$display("%0t: ok expected %0b actual %0b", $time, want_resp.okay, ok);
						err_count++;
					end
					if (free_count !== want_resp.count) begin
						$display("%0t: free_count expected %0d actual %0d",
							$time, want_resp.count, free_count);
						err_count++;
					end
				end
			end
			if (hold_request && !hold_done) begin
				hold_left <= LONG_HOLD;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, stall_cycles);
			$display("fixed_block_free_list_allocator_unit: mismatch");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		int unsigned blk;
		int unsigned pool;
		int sel;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: empty list, bad and good frees, unused kind, empty reinit
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		add_req(fbfla_pkg::KIND_FREE, '0);
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(8));
		add_req(fbfla_pkg::KIND_ALLOC, '1);
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		add_req(KIND_UNUSED, '1);
		add_req(fbfla_pkg::KIND_REINIT, '0);
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(4));
		wait_drained();

		// smallest block, four blocks: drain past empty, bad offsets, double free
		write_reg(fbfla_pkg::REG_UNIT_REQ, fbfla_pkg::CFG_W'(1));
		write_reg(fbfla_pkg::REG_POOL_LEN, fbfla_pkg::CFG_W'(40));
		add_req(fbfla_pkg::KIND_REINIT, '0);
		repeat (5) add_req(fbfla_pkg::KIND_ALLOC, '0);
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(WB + WB * MAXB));
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(13));
		add_req(fbfla_pkg::KIND_FREE, '1);
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(16));
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(16));
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		wait_drained();

		// zero block size, oversized pool: block count and free counter saturate
		write_reg(fbfla_pkg::REG_UNIT_REQ, fbfla_pkg::CFG_W'(0));
		write_reg(fbfla_pkg::REG_POOL_LEN, '1);
		add_req(fbfla_pkg::KIND_REINIT, '0);
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(8));
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		wait_drained();

		// largest block, full pool
		write_reg(fbfla_pkg::REG_UNIT_REQ, fbfla_pkg::CFG_W'(8191));
		write_reg(fbfla_pkg::REG_POOL_LEN, fbfla_pkg::CFG_W'(POOL_CAP));
		add_req(fbfla_pkg::KIND_REINIT, '0);
		add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'(WB + 8192 * 127));
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		add_req(fbfla_pkg::KIND_ALLOC, '0);
		wait_drained();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					blk = $urandom_range(0, 64);
				end
				6, 7: begin
					blk = $urandom_range(65, 4096);
				end
				default: begin
					blk = $urandom_range(4097, 8191);
				end
			endcase
			if ($urandom_range(0, 5) == 0) begin
				pool = $urandom_range(0, (1 << fbfla_pkg::POOL_W) - 1);
			end else begin
				pool = WB + unit_bytes(blk) * $urandom_range(0, 40)
					+ $urandom_range(0, unit_bytes(blk) - 1);
			end
			write_reg(fbfla_pkg::REG_UNIT_REQ, fbfla_pkg::CFG_W'(blk));
			write_reg(fbfla_pkg::REG_POOL_LEN, fbfla_pkg::CFG_W'(pool));
			no_idle <= (ph == 3);
			// sometimes keep the old geometry until a reinitialize comes along
			if ($urandom_range(0, 4) != 0) begin
				add_req(fbfla_pkg::KIND_REINIT, fbfla_pkg::OFF_W'($urandom));
			end
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				sel = $urandom_range(0, 99);
				if (sel < 42) begin
					add_req(fbfla_pkg::KIND_ALLOC, fbfla_pkg::OFF_W'($urandom));
				end else if (sel < 84) begin
					add_req(fbfla_pkg::KIND_FREE,
						fbfla_pkg::OFF_W'(WB + $urandom_range(0, gen_blocks + 1) * gen_unit));
				end else if (sel < 92) begin
					add_req(fbfla_pkg::KIND_FREE, fbfla_pkg::OFF_W'($urandom));
				end else if (sel < 96) begin
					add_req(fbfla_pkg::KIND_REINIT, fbfla_pkg::OFF_W'($urandom));
				end else begin
					add_req(KIND_UNUSED, fbfla_pkg::OFF_W'($urandom));
				end
			end
			if (ph == 1) begin
				hold_request <= 1'b1;
			end
			wait_drained();
		end

		repeat (30) @(posedge clk);
		if (err_count == 0) begin
			$display("fixed_block_free_list_allocator_unit: match");
		end else begin
			$display("fixed_block_free_list_allocator_unit: mismatch");
		end
		$finish;
	end

endmodule
